// ===== design/mvt_pkg.sv =====
// Shared types and constants for the 4x4 matrix vector transform block.
package mvt_pkg;

    // Vector and matrix dimension.
    localparam int DIM = 4;

    // Width of one Q-format element.
    localparam int ELEM_W = 32;

    // Width of one 32 x 32 signed product.
    localparam int PROD_W = 2 * ELEM_W;

    // Width of the exact sum of four products.
    localparam int SUM_W = PROD_W + 2;

    // Item kinds carried in the input tuser field.
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_XFORM = 1'b1;

    // Four elements packed side by side, index 0 in the lowest bits.
    typedef logic [DIM-1:0][ELEM_W-1:0] t_q4;

    // Whole matrix, element row*4+column at index row*4+column.
    typedef logic [DIM*DIM-1:0][ELEM_W-1:0] t_mat;

    // One finished output component.
    typedef struct packed {
        logic [ELEM_W-1:0] value;
        logic              sat;
    } t_col_res;

endpackage

// ===== design/mat4_vertex_transform.sv =====
// Top level of the 4x4 matrix vector transform block.
// This block holds a 4x4 matrix of signed fixed-point elements (FRAC_BITS fraction
// bits) that resets to the identity, and multiplies each incoming 4-vector by it,
// giving one result item per transform item and none per load item. The pipeline is
// five register stages deep, and a new item is taken in every cycle while no finished
// result waits on a stalled master side, so the sustained rate is one item per clock.
// That figure is set by the sixteen 32 x 32 multipliers, one per matrix element, each
// followed by its own register stage and a two-level adder tree per column. A load
// takes effect for every transform item accepted after it. When the master side
// stalls, the whole pipeline holds and the slave side drops tready.
module mat4_vertex_transform #(
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // elem_index[3:0], elem_value[35:4], vec_x[67:36], vec_y[99:68],
    // vec_z[131:100], vec_w[163:132], zero fill [167:164]
    input  logic [167:0] s_axis_tdata,
    // mode[0]
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64], out_w[127:96]
    output logic [127:0] m_axis_tdata,
    // saturated[0]
    output logic [0:0]   m_axis_tuser
);

    localparam int STAGES = 5;

    logic                       w_en;
    logic                       w_accept;
    logic                       w_load;
    mvt_pkg::t_mat              w_mat;
    logic [STAGES-1:0]          r_vld;
    mvt_pkg::t_q4               r_vec;
    mvt_pkg::t_q4               r_col [mvt_pkg::DIM];
    mvt_pkg::t_col_res          w_res [mvt_pkg::DIM];

    // The pipeline moves unless a finished result is waiting to be taken.
    assign w_en          = !(r_vld[STAGES-1] && !m_axis_tready);
    assign s_axis_tready = w_en;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_load        = w_accept && (s_axis_tuser[0] == mvt_pkg::MODE_LOAD);

    mvt_matrix_store #(
        .FRAC_BITS (FRAC_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_load),
        .i_wr_idx  (s_axis_tdata[3:0]),
        .i_wr_data (s_axis_tdata[35:4]),
        .o_mat     (w_mat)
    );

    // Valid bits travel alongside the data; only transform items enter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[STAGES-2:0],
                      w_accept && (s_axis_tuser[0] == mvt_pkg::MODE_XFORM)};
        end
    end

    // Stage one: the vector and a copy of the matrix, taken column by column.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_vec <= s_axis_tdata[163:36];
            for (int j = 0; j < mvt_pkg::DIM; j++) begin
                for (int r = 0; r < mvt_pkg::DIM; r++) begin
                    r_col[j][r] <= w_mat[r*mvt_pkg::DIM + j];
                end
            end
        end
    end

    // One column unit per output component.
    for (genvar j = 0; j < mvt_pkg::DIM; j++) begin : g_col
        mvt_column #(
            .FRAC_BITS (FRAC_BITS)
        ) u_column (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_vec (r_vec),
            .i_col (r_col[j]),
            .o_res (w_res[j])
        );
        assign m_axis_tdata[j*mvt_pkg::ELEM_W +: mvt_pkg::ELEM_W] = w_res[j].value;
    end

    // Result flags are gathered from the last stage.
    assign m_axis_tvalid   = r_vld[STAGES-1];
    assign m_axis_tuser[0] = w_res[0].sat | w_res[1].sat | w_res[2].sat | w_res[3].sat;

endmodule

// ===== design/mvt_matrix_store.sv =====
// Matrix element store, reset to the identity and written one element per load item.
module mvt_matrix_store #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_en,
    input  logic [3:0]           i_wr_idx,
    input  logic [31:0]          i_wr_data,
    output mvt_pkg::t_mat        o_mat
);

    logic [mvt_pkg::ELEM_W-1:0] r_mat [mvt_pkg::DIM*mvt_pkg::DIM];

    // Identity on reset; one element replaced per load item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < mvt_pkg::DIM; r++) begin
                for (int c = 0; c < mvt_pkg::DIM; c++) begin
                    if (r == c) begin
                        r_mat[r*mvt_pkg::DIM + c] <= mvt_pkg::ELEM_W'(1) << FRAC_BITS;
                    end else begin
                        r_mat[r*mvt_pkg::DIM + c] <= '0;
                    end
                end
            end
        end else if (i_wr_en) begin
            r_mat[i_wr_idx] <= i_wr_data;
        end
    end

    // Every element is visible at once to the transform pipeline.
    always_comb begin
        for (int i = 0; i < mvt_pkg::DIM * mvt_pkg::DIM; i++) begin
            o_mat[i] = r_mat[i];
        end
    end

endmodule

// ===== design/mvt_column.sv =====
// One output column: four products, a two-level adder tree, then shift and saturate.
module mvt_column #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  mvt_pkg::t_q4       i_vec,
    input  mvt_pkg::t_q4       i_col,
    output mvt_pkg::t_col_res  o_res
);

    localparam int PW = mvt_pkg::PROD_W;
    localparam int SW = mvt_pkg::SUM_W;

    logic signed [PW-1:0]   r_prod [mvt_pkg::DIM];
    logic signed [PW:0]     r_pair [2];
    logic signed [SW-1:0]   r_sum;
    mvt_pkg::t_col_res      r_res;
    logic signed [SW-1:0]   w_shift;
    logic                   w_pos_ovf;
    logic                   w_neg_ovf;
    mvt_pkg::t_col_res      n_res;

    // Stage two: one signed multiplier per row.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < mvt_pkg::DIM; r++) begin
                r_prod[r] <= $signed(i_col[r]) * $signed(i_vec[r]);
            end
        end
    end

    // Stage three: pairwise sums, one bit wider.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pair[0] <= (PW+1)'(r_prod[0]) + (PW+1)'(r_prod[1]);
            r_pair[1] <= (PW+1)'(r_prod[2]) + (PW+1)'(r_prod[3]);
        end
    end

    // Stage four: exact total of the four products.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= SW'(r_pair[0]) + SW'(r_pair[1]);
        end
    end

    // Arithmetic shift drops the fraction bits, rounding toward minus infinity,
    // and bit 31 and all bits above it must match the sign or the value is clipped.
    always_comb begin
        w_shift   = r_sum >>> FRAC_BITS;
        w_pos_ovf = !w_shift[SW-1] && (|w_shift[SW-2:mvt_pkg::ELEM_W-1]);
        w_neg_ovf = w_shift[SW-1] && !(&w_shift[SW-2:mvt_pkg::ELEM_W-1]);
        if (w_pos_ovf) begin
            n_res.value = {1'b0, {(mvt_pkg::ELEM_W-1){1'b1}}};
        end else if (w_neg_ovf) begin
            n_res.value = {1'b1, {(mvt_pkg::ELEM_W-1){1'b0}}};
        end else begin
            n_res.value = w_shift[mvt_pkg::ELEM_W-1:0];
        end
        n_res.sat = w_pos_ovf || w_neg_ovf;
    end

    // Stage five: saturated result held for the output port.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

// ===== design/mvt_checker.sv =====
// Port-level checks for the matrix vector transform block, bound to its top level.
module mvt_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata,
    input logic [0:0]   m_axis_tuser
);

    // A result offered and not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result item withdrawn while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result item changed while stalled");

    // The input side only stalls behind a waiting result.
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without a waiting result");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !m_axis_tvalid)
        else $error("result item offered right after reset");

endmodule

bind mat4_vertex_transform mvt_checker u_mvt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
